[src/assert_macros.svh]
// Assertion macros shared by the RTL. Simulation builds get concurrent
// assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WSS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`define WSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define WSS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define WSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

[src/wss_pkg.sv]
package wss_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int COURANT_BITS  = 17;
	localparam int COURANT_FRAC  = 16;
	localparam logic [COURANT_BITS-1:0] COURANT_RESET = COURANT_BITS'(37749);

	// Laplacian and base term each need two bits of headroom over a sample.
	localparam int LAP_W  = SAMPLE_BITS + 2;
	localparam int BASE_W = SAMPLE_BITS + 2;
	localparam int PROD_W = LAP_W + COURANT_BITS;
	localparam int Q_W    = PROD_W - COURANT_FRAC;
	localparam int V_W    = Q_W + 2;

	localparam int JOB_DEPTH = 4;
	localparam int PTR_W     = $clog2(JOB_DEPTH);
	localparam int CNT_W     = $clog2(JOB_DEPTH + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COURANT_BITS-1:0] courant_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		sample_t past_value;
		sample_t present_value;
		logic    half_step;
		logic    row_end;
	} in_item_t;

	typedef struct packed {
		sample_t future_value;
		logic    row_done;
	} out_item_t;

	// One pending stencil evaluation, already reduced to a magnitude to be
	// scaled by r and a base term to which the signed scaled value is added.
	typedef struct packed {
		logic              zero;
		logic              done;
		logic              half;
		logic              neg;
		logic [LAP_W-1:0]  mag;
		logic [BASE_W-1:0] base;
	} job_t;

	typedef struct packed {
		logic push_a;
		logic push_b;
		job_t job_a;
		job_t job_b;
	} job_push_t;

	typedef enum logic [2:0] {
		ROW_START  = 3'b001,
		ROW_SECOND = 3'b010,
		ROW_MIDDLE = 3'b100
	} row_pos_t;

	function automatic logic [LAP_W-1:0] ext_sample(sample_t x);
		return {{(LAP_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
	endfunction

	function automatic job_t build_job(sample_t left, sample_t mid, sample_t right,
			sample_t past, logic half, logic zero, logic done);
		logic [LAP_W-1:0] lap;
		job_t j;
		lap = ext_sample(left) + ext_sample(right) - (ext_sample(mid) << 1);
		j.zero = zero;
		j.done = done;
		j.half = half;
		j.neg  = lap[LAP_W-1];
		j.mag  = lap[LAP_W-1] ? (~lap + LAP_W'(1)) : lap;
		j.base = half ? ext_sample(mid) : ((ext_sample(mid) << 1) - ext_sample(past));
		return j;
	endfunction

endpackage

[src/wss_window.sv]
module wss_window import wss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_item_t  item,
	output job_push_t push
);

	row_pos_t pos_q;
	sample_t  left_q;
	sample_t  mid_q;
	sample_t  past_q;
	logic     half_q;

	// The first job is the result for the held middle point; on the first
	// point of a row it only exists for a single-point row and is zero.
	// The second job flushes the last point with a zero right neighbor.
	always_comb begin
		push.push_a = accept && ((pos_q != ROW_START) || item.row_end);
		push.push_b = accept && (pos_q != ROW_START) && item.row_end;
		push.job_a  = build_job(left_q, mid_q, item.present_value, past_q, half_q,
			pos_q != ROW_MIDDLE, pos_q == ROW_START);
		push.job_b  = build_job(mid_q, item.present_value, '0, item.past_value, half_q,
			1'b0, 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= ROW_START;
			left_q <= '0;
			mid_q  <= '0;
			past_q <= '0;
			half_q <= 1'b0;
		end else if (accept) begin
			case (pos_q)
				ROW_START: begin
					half_q <= item.half_step;
					left_q <= '0;
					pos_q  <= item.row_end ? ROW_START : ROW_SECOND;
				end
				default: begin
					left_q <= mid_q;
					pos_q  <= item.row_end ? ROW_START : ROW_MIDDLE;
				end
			endcase
			mid_q  <= item.present_value;
			past_q <= item.past_value;
		end
	end

endmodule

[src/wss_eval.sv]
module wss_eval import wss_pkg::*; (
	input  job_t     job,
	input  courant_t courant,
	output sample_t  value
);

	localparam logic [PROD_W-1:0] ROUND_FULL = PROD_W'(1) << (COURANT_FRAC - 1);
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << COURANT_FRAC;

	logic [PROD_W-1:0] product;
	logic [PROD_W-1:0] rounded;
	logic [Q_W-1:0]    q;
	logic [V_W-1:0]    q_ext;
	logic [V_W-1:0]    base_ext;
	logic [V_W-1:0]    v;
	logic              in_range;

	// Rounding half away from zero: scale the magnitude, then restore the sign.
	always_comb begin
		product  = PROD_W'(job.mag) * PROD_W'(courant);
		rounded  = product + (job.half ? ROUND_HALF : ROUND_FULL);
		q        = job.half ? Q_W'(rounded >> (COURANT_FRAC + 1))
			: Q_W'(rounded >> COURANT_FRAC);
		q_ext    = {2'b00, q};
		base_ext = {{(V_W-BASE_W){job.base[BASE_W-1]}}, job.base};
		v        = base_ext + (job.neg ? (~q_ext + V_W'(1)) : q_ext);
		in_range = (&v[V_W-1:SAMPLE_BITS-1]) || !(|v[V_W-1:SAMPLE_BITS-1]);
		if (job.zero) begin
			value = '0;
		end else if (in_range) begin
			value = v[SAMPLE_BITS-1:0];
		end else begin
			value = v[V_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
		end
	end

endmodule

[src/wave_string_stencil_step_core.sv]
// Channel  Handshake                  Payload
// item     item_valid / item_ready    item (in_item_t)
// result   result_valid / result_ready result (out_item_t)
// config   cfg_wen                    cfg_wdata (courant_squared)
//
// One item is accepted per cycle while the job queue has two free entries.
// Results leave the queue at one per cycle, unless a held result stalls it, through one
// multiplier into the result register; a result is registered once its job is at the head.
// A row end of a multi-point row queues two jobs; the four-entry queue absorbs that burst.
// Reset clears the row position, the queue, the result valid and sets r to 37749.
// A stalled result holds the queue head; input stalls once fewer than two entries are free.
`include "assert_macros.svh"

module wave_string_stencil_step_core import wss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  in_item_t   item,
	output logic       result_valid,
	input  logic       result_ready,
	output out_item_t  result,
	input  logic       cfg_wen,
	input  courant_t   cfg_wdata
);

	courant_t         courant_q;
	job_t             job_fifo_q [JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] job_count_q;
	logic             result_valid_q;
	out_item_t        result_q;

	logic      accept;
	logic      pop;
	job_push_t push;
	job_t      head;
	sample_t   head_value;

	assign item_ready   = job_count_q <= CNT_W'(JOB_DEPTH - 2);
	assign accept       = item_valid && item_ready;
	assign pop          = (job_count_q != '0) && (!result_valid_q || result_ready);
	assign head         = job_fifo_q[rd_ptr_q];
	assign result_valid = result_valid_q;
	assign result       = result_q;

	wss_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.push   (push)
	);

	wss_eval u_eval (
		.job     (head),
		.courant (courant_q),
		.value   (head_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q <= COURANT_RESET;
		end else if (cfg_wen) begin
			courant_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push_a) begin
			job_fifo_q[wr_ptr_q] <= push.job_a;
		end
		if (push.push_b) begin
			job_fifo_q[wr_ptr_q + PTR_W'(1)] <= push.job_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			job_count_q <= '0;
		end else begin
			wr_ptr_q    <= wr_ptr_q + PTR_W'(push.push_a) + PTR_W'(push.push_b);
			rd_ptr_q    <= rd_ptr_q + PTR_W'(pop);
			job_count_q <= job_count_q + CNT_W'(push.push_a) + CNT_W'(push.push_b)
				- CNT_W'(pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.future_value <= head_value;
			result_q.row_done     <= head.done;
		end
	end

	`WSS_ASSERT_ALWAYS(job_count_bounded, clk, arst_n, job_count_q <= CNT_W'(JOB_DEPTH))
	`WSS_ASSERT_ALWAYS(job_count_matches_ptrs, clk, arst_n,
		job_count_q[PTR_W-1:0] == PTR_W'(wr_ptr_q - rd_ptr_q))
	`WSS_ASSERT_IMPLIES(flush_follows_middle, clk, arst_n, push.push_b, push.push_a)
	`WSS_ASSERT_IMPLIES(result_from_queue, clk, arst_n, $rose(result_valid_q),
		$past(job_count_q) != '0)

endmodule
